// ===== rtl/core/ttt_pkg.sv =====
// Shared types and constants of the connection timer table.
// Used by the channel interfaces, the slot cell and the top level.
package ttt_pkg;

    localparam int SLOT_W = 4;   // width of a slot number
    localparam int CMD_W  = 2;   // width of a command code
    localparam int EV_W   = 3;   // width of an event code
    localparam int TW_W   = 12;  // time-wait counter width
    localparam int RT_W   = 20;  // retransmit counter width
    localparam int TRY_W  = 3;   // retry counter width
    localparam int CFG_W  = 12;  // widest configuration register
    localparam int CIDX_W = 2;   // configuration register index width

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ARM_TW    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ARM_RT    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DISARM_RT = 2'd3;

    // Event codes.
    localparam logic [EV_W-1:0] EV_ACK    = 3'd0;
    localparam logic [EV_W-1:0] EV_NONE   = 3'd1;
    localparam logic [EV_W-1:0] EV_CLOSE  = 3'd2;
    localparam logic [EV_W-1:0] EV_RETX   = 3'd3;
    localparam logic [EV_W-1:0] EV_GIVEUP = 3'd4;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_TIMEWAIT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_RT_BASE  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_TRY  = 2'd2;

    typedef struct packed {
        logic [TW_W-1:0]  timewait;
        logic [TW_W-1:0]  rt_base;
        logic [TRY_W-1:0] max_retries;
    } t_cell_cfg;

    typedef struct packed {
        logic shift;     // move the walk token one cell along
        logic arm_tw;    // arm this cell's time-wait timer
        logic arm_rt;    // arm this cell's retransmit timer
        logic disarm_rt; // stop this cell's retransmit timer
    } t_cell_ctl;

    typedef struct packed {
        logic            hit;
        logic [EV_W-1:0] code;
    } t_cell_evt;

endpackage

// ===== rtl/core/ttt_cmd_if.sv =====
// Command channel of the connection timer table: one beat per command.
// Depends on ttt_pkg for the field widths.
interface ttt_cmd_if import ttt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output command, output slot, input ready);
    modport sink   (input valid, input command, input slot, output ready);
endinterface

// ===== rtl/core/ttt_evt_if.sv =====
// Event channel of the connection timer table: one beat per reported event.
// Depends on ttt_pkg for the field widths.
interface ttt_evt_if import ttt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot_res;
    logic [EV_W-1:0]   event_res;
    logic              last;

    modport source (output valid, output slot_res, output event_res, output last, input ready);
    modport sink   (input valid, input slot_res, input event_res, input last, output ready);
endinterface

// ===== rtl/core/tcp_timer_table.sv =====
// Connection timer table: a row of slot cells with time-wait and retransmit timers.
// Arm and disarm commands answer with one beat, registered in the cycle after acceptance.
// A tick walks the token through SLOTS cells, one per cycle while the event channel does not stall,
// then flushes; one command is in work at a time.
// Reset (synchronous, active low) clears all timers and loads the default configuration.
// Depends on ttt_pkg, ttt_cmd_if, ttt_evt_if and ttt_cell.
module tcp_timer_table import ttt_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ttt_cmd_if.sink           i_cmd,
    ttt_evt_if.source         o_evt,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    // Controller states. IDLE takes commands, WALK moves the token down the
    // row of cells, FLUSH sends the final beat of a tick.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    t_cell_cfg         r_cfg;
    logic [SLOT_W-1:0] r_idx;

    // Output register of the event channel.
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [EV_W-1:0]   r_out_ev;
    logic              r_out_last;

    // One event is held back during a walk so that the final one can carry
    // the last flag once the walk knows no further slot expired.
    logic              r_pend_valid;
    logic [SLOT_W-1:0] r_pend_slot;
    logic [EV_W-1:0]   r_pend_ev;

    logic              out_free;
    logic              cmd_acc;
    logic              tick_start;
    logic              walk_step;
    logic              end_of_row;
    t_cell_evt         evt_any;

    logic      [SLOTS:0]   tok_chain;
    t_cell_ctl             cell_ctl [SLOTS];
    t_cell_evt             cell_evt [SLOTS];

    // -------------------------------------------------------------------
    // Configuration registers.
    // -------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timewait    <= TW_W'(60);
            r_cfg.rt_base     <= TW_W'(2);
            r_cfg.max_retries <= TRY_W'(3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEWAIT: r_cfg.timewait    <= i_cfg_data;
                CFG_RT_BASE:  r_cfg.rt_base     <= i_cfg_data;
                CFG_MAX_TRY:  r_cfg.max_retries <= i_cfg_data[TRY_W-1:0];
                default:      ;
            endcase
        end
    end

    // -------------------------------------------------------------------
    // Handshake and walk control.
    // -------------------------------------------------------------------
    assign out_free     = !r_out_valid || o_evt.ready;
    assign i_cmd.ready  = (r_state == ST_IDLE) && out_free;
    assign cmd_acc      = i_cmd.valid && i_cmd.ready;
    assign tick_start   = cmd_acc && (i_cmd.command == CMD_TICK);
    assign walk_step    = (r_state == ST_WALK) && out_free;
    // The token sits in the last cell and moves out on this step.
    assign end_of_row   = walk_step && tok_chain[SLOTS];

    assign tok_chain[0] = tick_start;

    // -------------------------------------------------------------------
    // Row of slot cells. The token enters cell 0 on a tick and moves one
    // cell per step; the cell holding it counts down its timers.
    // -------------------------------------------------------------------
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        always_comb begin
            cell_ctl[k].shift     = tick_start || walk_step;
            cell_ctl[k].arm_tw    = cmd_acc && (i_cmd.command == CMD_ARM_TW)
                                    && (i_cmd.slot == SLOT_W'(k));
            cell_ctl[k].arm_rt    = cmd_acc && (i_cmd.command == CMD_ARM_RT)
                                    && (i_cmd.slot == SLOT_W'(k));
            cell_ctl[k].disarm_rt = cmd_acc && (i_cmd.command == CMD_DISARM_RT)
                                    && (i_cmd.slot == SLOT_W'(k));
        end

        ttt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_ctl   (cell_ctl[k]),
            .i_tok   (tok_chain[k]),
            .o_tok   (tok_chain[k+1]),
            .o_evt   (cell_evt[k])
        );
    end

    // Only the cell with the token reports, so the others give zeros.
    always_comb begin
        evt_any = '0;
        for (int k = 0; k < SLOTS; k++) begin
            evt_any = evt_any | cell_evt[k];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (tick_start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (end_of_row) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cmd_acc && (i_cmd.command != CMD_TICK)) begin
                r_out_valid <= 1'b1;
            end
            if (walk_step && evt_any.hit) begin
                // A newer event pushes the held one out as a middle beat.
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                end
                r_pend_valid <= 1'b1;
            end
            if ((r_state == ST_FLUSH) && out_free) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_start) begin
            r_idx <= '0;
        end else if (walk_step) begin
            r_idx <= r_idx + SLOT_W'(1);
        end

        if (cmd_acc && (i_cmd.command != CMD_TICK)) begin
            // Acknowledge, also for a slot beyond the table.
            r_out_slot <= i_cmd.slot;
            r_out_ev   <= EV_ACK;
            r_out_last <= 1'b1;
        end else if (walk_step && evt_any.hit) begin
            r_out_slot <= r_pend_slot;
            r_out_ev   <= r_pend_ev;
            r_out_last <= 1'b0;
        end else if ((r_state == ST_FLUSH) && out_free) begin
            r_out_last <= 1'b1;
            if (r_pend_valid) begin
                r_out_slot <= r_pend_slot;
                r_out_ev   <= r_pend_ev;
            end else begin
                r_out_slot <= '0;
                r_out_ev   <= EV_NONE;
            end
        end

        if (walk_step && evt_any.hit) begin
            r_pend_slot <= r_idx;
            r_pend_ev   <= evt_any.code;
        end
    end

    assign o_evt.valid     = r_out_valid;
    assign o_evt.slot_res  = r_out_slot;
    assign o_evt.event_res = r_out_ev;
    assign o_evt.last      = r_out_last;

endmodule

// ===== rtl/core/ttt_cell.sv =====
// One slot of the timer table: both timers, the retry count and a walk token.
// Depends on ttt_pkg for the control, configuration and event types.
module ttt_cell import ttt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cfg i_cfg,
    input  t_cell_ctl i_ctl,
    input  logic      i_tok,
    output logic      o_tok,
    output t_cell_evt o_evt
);

    logic             r_tok;
    logic             r_tw_act;
    logic             r_rt_act;
    logic [TW_W-1:0]  r_tw_rem;
    logic [RT_W-1:0]  r_rt_rem;
    logic [TRY_W-1:0] r_rt_try;

    logic            visit;
    logic            tw_exp;
    logic            rt_exp;
    logic            give_up;
    logic [3:0]      shamt;
    logic [RT_W-1:0] n_rt_reload;

    always_comb begin
        visit   = i_ctl.shift && r_tok;
        tw_exp  = r_tw_act && (r_tw_rem <= TW_W'(1));
        rt_exp  = r_rt_act && !tw_exp && (r_rt_rem <= RT_W'(1));
        give_up = rt_exp && (r_rt_try >= i_cfg.max_retries);
        // Backoff uses the incremented retry count, plus one more doubling.
        shamt       = {1'b0, r_rt_try} + 4'd2;
        n_rt_reload = RT_W'(i_cfg.rt_base) << shamt;

        o_evt.hit  = visit && (tw_exp || rt_exp);
        o_evt.code = EV_ACK;
        if (o_evt.hit) begin
            if (tw_exp) begin
                o_evt.code = EV_CLOSE;
            end else if (give_up) begin
                o_evt.code = EV_GIVEUP;
            end else begin
                o_evt.code = EV_RETX;
            end
        end
    end

    assign o_tok = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= 1'b0;
            r_tw_act <= 1'b0;
            r_rt_act <= 1'b0;
        end else begin
            if (i_ctl.shift) begin
                r_tok <= i_tok;
            end
            if (i_ctl.arm_tw) begin
                r_tw_act <= 1'b1;
            end
            if (i_ctl.arm_rt) begin
                r_rt_act <= 1'b1;
            end
            if (i_ctl.disarm_rt) begin
                r_rt_act <= 1'b0;
            end
            if (visit && (tw_exp || give_up)) begin
                r_tw_act <= 1'b0;
                r_rt_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.arm_tw) begin
            r_tw_rem <= i_cfg.timewait;
        end else if (visit && r_tw_act && !tw_exp) begin
            r_tw_rem <= r_tw_rem - TW_W'(1);
        end

        if (i_ctl.arm_rt) begin
            r_rt_rem <= RT_W'(i_cfg.rt_base);
            r_rt_try <= '0;
        end else if (visit && r_rt_act && !tw_exp) begin
            if (rt_exp) begin
                if (!give_up) begin
                    r_rt_try <= r_rt_try + TRY_W'(1);
                    r_rt_rem <= n_rt_reload;
                end
            end else begin
                r_rt_rem <= r_rt_rem - RT_W'(1);
            end
        end
    end

endmodule
